@@ sv/ufcc_pkg.sv @@
// Shared types, constants and helpers for the union-find component counter.
package ufcc_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ELEM_W       = 11;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int RANK_W       = 4;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 16;
  localparam int OUT_PAD_W    = OUT_DATA_W - ELEM_W - 1;
  localparam int IN_PAD_W     = IN_DATA_W - 2 * ELEM_W;

  localparam logic [ELEM_W-1:0] COUNT_RESET = ELEM_W'(MAX_ELEMENTS);
  localparam logic [RANK_W-1:0] RANK_MAX    = {RANK_W{1'b1}};
  localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(MAX_ELEMENTS - 1);

  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_COMP_A,
    ST_FIND_B,
    ST_COMP_B,
    ST_LINK,
    ST_LINK2
  } state_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ELEM_W-1:0] parent;
  } entry_t;

  // element e lives at address e-1
  function automatic logic [ADDR_W-1:0] addr_of(input logic [ELEM_W-1:0] e);
    logic [ELEM_W-1:0] d;
    d = e - ELEM_W'(1);
    return d[ADDR_W-1:0];
  endfunction

  function automatic logic [ELEM_W-1:0] clamp_count(input logic [ELEM_W-1:0] v);
    logic [ELEM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = ELEM_W'(1);
    end else if (v > COUNT_RESET) begin
      r = COUNT_RESET;
    end
    return r;
  endfunction

endpackage

@@ sv/ufcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ufcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/union_find_component_counter_core.sv @@
// Union-find component counter: disjoint sets with union by rank and path compression.
//
// Input stream (s_*): s_tuser is the request kind (0 merge, 1 query); s_tdata holds
// elem_a and elem_b. A query transaction is answered on the output stream (m_*) with
// the live component count and the sticky bad-index flag; a merge produces nothing.
// A query's result is registered into the output register when the query is accepted.
// A merge walks the parent chain of elem_a, rewrites it to point at the root, then does
// the same for elem_b, one read and one write per cycle on the parent/rank RAM, then
// links the roots, with a second write on a rank tie to raise the rank; s_tready stays
// low until the merge is done.
// A merge naming an element of 0 or above element_count is dropped and sets the
// bad-index flag.
// After reset, and after every write of element_count (cfg_we/cfg_wdata, to be written
// only while idle), a clearing pass rewrites all 1024 table entries, one per cycle; no
// transaction is accepted during the pass.
// s_tready is low while a merge is in progress and while an unconsumed result would
// block a new query; a stalled receiver holds the result in the output register.
module union_find_component_counter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ufcc_pkg::ELEM_W-1:0]     cfg_wdata,   // element_count
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ufcc_pkg::IN_DATA_W-1:0]  s_tdata,     // elem_a, elem_b, zero pad
  input  logic                            s_tuser,     // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ufcc_pkg::OUT_DATA_W-1:0] m_tdata      // component_count, bad_index, pad
);

  ufcc_pkg::state_t state, state_next;

  logic [ufcc_pkg::ELEM_W-1:0] element_count;
  logic [ufcc_pkg::ELEM_W-1:0] live;
  logic                        error_seen;
  logic [ufcc_pkg::ADDR_W-1:0] clr_addr;

  logic [ufcc_pkg::ELEM_W-1:0] cur, cur_next;
  logic [ufcc_pkg::ELEM_W-1:0] a_hold, b_hold;
  logic [ufcc_pkg::ELEM_W-1:0] root_a, root_b;
  logic [ufcc_pkg::RANK_W-1:0] rank_a, rank_b;

  logic [ufcc_pkg::ELEM_W-1:0] out_count;
  logic                        out_bad;

  logic                        ram_we;
  logic [ufcc_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  ufcc_pkg::entry_t            ram_wdata, ram_rdata;

  logic [ufcc_pkg::ELEM_W-1:0] in_a, in_b;
  logic                        in_acc, in_bad, is_root;

  assign in_a    = s_tdata[ufcc_pkg::ELEM_W-1:0];
  assign in_b    = s_tdata[2*ufcc_pkg::ELEM_W-1:ufcc_pkg::ELEM_W];
  assign in_acc  = s_tvalid && s_tready;
  assign in_bad  = (in_a == '0) || (in_b == '0) || (in_a > element_count) ||
                   (in_b > element_count);
  assign is_root = (ram_rdata.parent == cur);

  assign m_tdata = {{ufcc_pkg::OUT_PAD_W{1'b0}}, out_bad, out_count};

  ufcc_ram #(
    .WIDTH($bits(ufcc_pkg::entry_t)),
    .DEPTH(ufcc_pkg::MAX_ELEMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ufcc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ufcc_pkg::addr_of(cur);
    ram_wdata  = '{rank: ram_rdata.rank, parent: root_a};
    ram_raddr  = ufcc_pkg::addr_of(cur);
    case (state)
      ufcc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '{rank: '0, parent: {1'b0, clr_addr} + ufcc_pkg::ELEM_W'(1)};
        if (clr_addr == ufcc_pkg::ADDR_LAST) begin
          state_next = ufcc_pkg::ST_IDLE;
        end
      end
      ufcc_pkg::ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (in_acc && (s_tuser == ufcc_pkg::REQ_MERGE) && !in_bad) begin
          cur_next   = in_a;
          ram_raddr  = ufcc_pkg::addr_of(in_a);
          state_next = ufcc_pkg::ST_FIND_A;
        end
      end
      ufcc_pkg::ST_FIND_A, ufcc_pkg::ST_FIND_B: begin
        if (is_root) begin
          cur_next   = (state == ufcc_pkg::ST_FIND_A) ? a_hold : b_hold;
          ram_raddr  = ufcc_pkg::addr_of(cur_next);
          state_next = (state == ufcc_pkg::ST_FIND_A) ? ufcc_pkg::ST_COMP_A
                                                      : ufcc_pkg::ST_COMP_B;
        end else begin
          cur_next  = ram_rdata.parent;
          ram_raddr = ufcc_pkg::addr_of(ram_rdata.parent);
        end
      end
      ufcc_pkg::ST_COMP_A: begin
        if (cur == root_a) begin
          cur_next   = b_hold;
          ram_raddr  = ufcc_pkg::addr_of(b_hold);
          state_next = ufcc_pkg::ST_FIND_B;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{rank: ram_rdata.rank, parent: root_a};
          cur_next  = ram_rdata.parent;
          ram_raddr = ufcc_pkg::addr_of(ram_rdata.parent);
        end
      end
      ufcc_pkg::ST_COMP_B: begin
        if (cur == root_b) begin
          state_next = ufcc_pkg::ST_LINK;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{rank: ram_rdata.rank, parent: root_b};
          cur_next  = ram_rdata.parent;
          ram_raddr = ufcc_pkg::addr_of(ram_rdata.parent);
        end
      end
      ufcc_pkg::ST_LINK: begin
        state_next = ufcc_pkg::ST_IDLE;
        if (root_a != root_b) begin
          ram_we = 1'b1;
          if (rank_a < rank_b) begin
            ram_waddr = ufcc_pkg::addr_of(root_a);
            ram_wdata = '{rank: rank_a, parent: root_b};
          end else begin
            ram_waddr = ufcc_pkg::addr_of(root_b);
            ram_wdata = '{rank: rank_b, parent: root_a};
            if (rank_a == rank_b) begin
              state_next = ufcc_pkg::ST_LINK2;
            end
          end
        end
      end
      ufcc_pkg::ST_LINK2: begin
        ram_we     = 1'b1;
        ram_waddr  = ufcc_pkg::addr_of(root_a);
        ram_wdata  = '{rank: (rank_a == ufcc_pkg::RANK_MAX) ? rank_a
                                                          : rank_a + ufcc_pkg::RANK_W'(1),
                       parent: root_a};
        state_next = ufcc_pkg::ST_IDLE;
      end
      default: begin
        state_next = ufcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ufcc_pkg::COUNT_RESET;
      live          <= ufcc_pkg::COUNT_RESET;
      error_seen    <= 1'b0;
      clr_addr      <= '0;
      m_tvalid      <= 1'b0;
    end else if (cfg_we) begin
      element_count <= ufcc_pkg::clamp_count(cfg_wdata);
      live          <= ufcc_pkg::clamp_count(cfg_wdata);
      error_seen    <= 1'b0;
      clr_addr      <= '0;
    end else begin
      if (state == ufcc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ufcc_pkg::ADDR_W'(1);
      end
      if (in_acc && (s_tuser == ufcc_pkg::REQ_MERGE) && in_bad) begin
        error_seen <= 1'b1;
      end
      if (state == ufcc_pkg::ST_LINK && root_a != root_b && live != '0) begin
        live <= live - ufcc_pkg::ELEM_W'(1);
      end
      if (in_acc && (s_tuser == ufcc_pkg::REQ_QUERY)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (in_acc) begin
      a_hold <= in_a;
      b_hold <= in_b;
    end
    if (in_acc && (s_tuser == ufcc_pkg::REQ_QUERY)) begin
      out_count <= live;
      out_bad   <= error_seen;
    end
    if (state == ufcc_pkg::ST_FIND_A && is_root) begin
      root_a <= cur;
      rank_a <= ram_rdata.rank;
    end
    if (state == ufcc_pkg::ST_FIND_B && is_root) begin
      root_b <= cur;
      rank_b <= ram_rdata.rank;
    end
  end

  a_live_bounded: assert property (@(posedge clk) disable iff (rst)
    live <= element_count)
    else $error("component count above element count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (element_count != '0) && (element_count <= ufcc_pkg::COUNT_RESET))
    else $error("element count out of range");

  a_live_step: assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> (live == $past(live)) || (live == $past(live) - ufcc_pkg::ELEM_W'(1)))
    else $error("component count moved by more than one");

  a_comp_no_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == ufcc_pkg::ST_COMP_A || state == ufcc_pkg::ST_COMP_B)
    |-> ram_waddr != ram_raddr)
    else $error("compression write collides with chain read");

endmodule

@@ tb/sv/union_find_component_counter_core_tb.sv @@
// Testbench for the union-find component counter: directed and random merge/query traffic.
`timescale 1ns / 1ps

module union_find_component_counter_core_tb;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 8000;

  typedef struct packed {
    logic [ufcc_pkg::ELEM_W-1:0] count;
    logic                        bad;
  } count_reply_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ufcc_pkg::ELEM_W-1:0]     cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ufcc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ufcc_pkg::OUT_DATA_W-1:0] m_tdata;

  // shadow disjoint-set state
  logic [ufcc_pkg::ELEM_W-1:0] set_parent [1:ufcc_pkg::MAX_ELEMENTS];
  logic [ufcc_pkg::RANK_W-1:0] set_rank [1:ufcc_pkg::MAX_ELEMENTS];
  logic [ufcc_pkg::ELEM_W-1:0] set_size;
  logic [ufcc_pkg::ELEM_W-1:0] live_sets;
  logic                        bad_seen;

  count_reply_t pending_replies [$];
  int fails = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  union_find_component_counter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reload_sets(input logic [ufcc_pkg::ELEM_W-1:0] value);
    logic [ufcc_pkg::ELEM_W-1:0] n;
    n = value;
    if (n == '0) begin
      n = ufcc_pkg::ELEM_W'(1);
    end else if (n > ufcc_pkg::ELEM_W'(ufcc_pkg::MAX_ELEMENTS)) begin
      n = ufcc_pkg::ELEM_W'(ufcc_pkg::MAX_ELEMENTS);
    end
    set_size = n;
    for (int i = 1; i <= ufcc_pkg::MAX_ELEMENTS; i++) begin
      set_parent[i] = ufcc_pkg::ELEM_W'(i);
      set_rank[i]   = '0;
    end
    live_sets = n;
    bad_seen  = 1'b0;
  endfunction

  function automatic logic [ufcc_pkg::ELEM_W-1:0] find_and_compress(
    input logic [ufcc_pkg::ELEM_W-1:0] node);
    logic [ufcc_pkg::ELEM_W-1:0] root;
    logic [ufcc_pkg::ELEM_W-1:0] cur;
    logic [ufcc_pkg::ELEM_W-1:0] nxt;
    root = node;
    while (set_parent[root] != root) begin
      root = set_parent[root];
    end
    cur = node;
    while (cur != root) begin
      nxt = set_parent[cur];
      set_parent[cur] = root;
      cur = nxt;
    end
    return root;
  endfunction

  function automatic void merge_sets(input logic [ufcc_pkg::ELEM_W-1:0] a,
                                     input logic [ufcc_pkg::ELEM_W-1:0] b);
    logic [ufcc_pkg::ELEM_W-1:0] ra;
    logic [ufcc_pkg::ELEM_W-1:0] rb;
    if (a == '0 || b == '0 || a > set_size || b > set_size) begin
      bad_seen = 1'b1;
      return;
    end
    ra = find_and_compress(a);
    rb = find_and_compress(b);
    if (ra == rb) begin
      return;
    end
    if (set_rank[ra] > set_rank[rb]) begin
      set_parent[rb] = ra;
    end else if (set_rank[ra] < set_rank[rb]) begin
      set_parent[ra] = rb;
    end else begin
      set_parent[rb] = ra;
      if (set_rank[ra] < ufcc_pkg::RANK_MAX) begin
        set_rank[ra] = set_rank[ra] + 1'b1;
      end
    end
    if (live_sets > 0) begin
      live_sets = live_sets - 1'b1;
    end
  endfunction

  task automatic send_request(input logic kind, input logic [ufcc_pkg::ELEM_W-1:0] a,
                              input logic [ufcc_pkg::ELEM_W-1:0] b);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{ufcc_pkg::IN_PAD_W{1'b0}}, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == ufcc_pkg::REQ_QUERY) begin
      pending_replies.push_back('{count: live_sets, bad: bad_seen});
    end else begin
      merge_sets(a, b);
    end
  endtask

  task automatic write_element_count(input logic [ufcc_pkg::ELEM_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!s_tready) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    reload_sets(value);
  endtask

  task automatic drive_random_requests(input int n_items);
    logic                        kind;
    logic [ufcc_pkg::ELEM_W-1:0] a;
    logic [ufcc_pkg::ELEM_W-1:0] b;
    int                          pick;
    int                          hi;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      hi   = (set_size > 64 && $urandom_range(0, 1) == 1) ? 64 : int'(set_size);
      kind = ufcc_pkg::REQ_MERGE;
      a    = ufcc_pkg::ELEM_W'($urandom_range(1, hi));
      b    = ufcc_pkg::ELEM_W'($urandom_range(1, hi));
      if (pick < 15) begin
        kind = ufcc_pkg::REQ_QUERY;
        a    = ufcc_pkg::ELEM_W'($urandom);
        b    = ufcc_pkg::ELEM_W'($urandom);
      end else if (pick < 21) begin
        case ($urandom_range(0, 3))
          0: a = '0;
          1: b = set_size + 1'b1;
          2: begin
            a = ufcc_pkg::ELEM_W'($urandom);
            b = ufcc_pkg::ELEM_W'($urandom);
          end
          default: a = {ufcc_pkg::ELEM_W{1'b1}};
        endcase
      end
      send_request(kind, a, b);
    end
  endtask

  // reset value 1024, extreme indices, same set, same element, bad indices
  task automatic test_directed_extremes();
    send_request(ufcc_pkg::REQ_QUERY, {ufcc_pkg::ELEM_W{1'b1}}, {ufcc_pkg::ELEM_W{1'b1}});
    send_request(ufcc_pkg::REQ_MERGE, 11'd1, 11'd1024);
    send_request(ufcc_pkg::REQ_MERGE, 11'd1024, 11'd1);
    send_request(ufcc_pkg::REQ_MERGE, 11'd512, 11'd512);
    send_request(ufcc_pkg::REQ_QUERY, '0, '0);
    send_request(ufcc_pkg::REQ_MERGE, 11'd0, 11'd5);
    send_request(ufcc_pkg::REQ_MERGE, 11'd5, 11'd1025);
    send_request(ufcc_pkg::REQ_QUERY, 11'd3, 11'd7);
    send_request(ufcc_pkg::REQ_MERGE, {ufcc_pkg::ELEM_W{1'b1}}, {ufcc_pkg::ELEM_W{1'b1}});
    send_request(ufcc_pkg::REQ_MERGE, 11'd1023, 11'd2);
    send_request(ufcc_pkg::REQ_QUERY, 11'd0, 11'd0);
  endtask

  // zero taken as one element; overlarge value taken as the maximum
  task automatic test_count_clamp();
    write_element_count('0);
    send_request(ufcc_pkg::REQ_QUERY, '0, '0);
    send_request(ufcc_pkg::REQ_MERGE, 11'd1, 11'd1);
    send_request(ufcc_pkg::REQ_MERGE, 11'd1, 11'd2);
    send_request(ufcc_pkg::REQ_QUERY, '0, '0);
    write_element_count({ufcc_pkg::ELEM_W{1'b1}});
    send_request(ufcc_pkg::REQ_QUERY, '0, '0);
  endtask

  // rank ties, both unequal-rank links, compression of a deep path
  task automatic test_rank_links();
    write_element_count(11'd8);
    send_request(ufcc_pkg::REQ_MERGE, 11'd1, 11'd2);
    send_request(ufcc_pkg::REQ_MERGE, 11'd3, 11'd4);
    send_request(ufcc_pkg::REQ_MERGE, 11'd1, 11'd3);
    send_request(ufcc_pkg::REQ_MERGE, 11'd5, 11'd1);
    send_request(ufcc_pkg::REQ_MERGE, 11'd4, 11'd6);
    send_request(ufcc_pkg::REQ_MERGE, 11'd7, 11'd8);
    send_request(ufcc_pkg::REQ_MERGE, 11'd8, 11'd2);
    send_request(ufcc_pkg::REQ_QUERY, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [ufcc_pkg::ELEM_W-1:0] sizes [10];
    int                          gaps [3];
    int                          stalls [3];
    sizes  = '{11'd3, 11'd2, 11'd1024, 11'd40, {ufcc_pkg::ELEM_W{1'b1}}, 11'd12, 11'd1025,
               11'd1, 11'd200, 11'd6};
    gaps   = '{0, 30, 60};
    stalls = '{50, 0, 30};
    sizes[7] = ufcc_pkg::ELEM_W'($urandom_range(1, 1100));
    for (int p = 0; p < 10; p++) begin
      gap_pct   = gaps[p % 3];
      stall_pct = stalls[(p / 3) % 3];
      write_element_count(sizes[p]);
      drive_random_requests(170);
    end
  endtask

  task automatic test_unthrottled_tail();
    gap_pct   = 0;
    stall_pct = 0;
    write_element_count(11'd24);
    drive_random_requests(250);
  endtask

  initial begin
    forever begin
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    count_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count=%0d bad=%0d",
                 $time, m_tdata[ufcc_pkg::ELEM_W-1:0], m_tdata[ufcc_pkg::ELEM_W]);
        fails++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[ufcc_pkg::ELEM_W-1:0] !== want.count) begin
          $display("%0t: component_count mismatch, expected %0d, actual %0d",
                   $time, want.count, m_tdata[ufcc_pkg::ELEM_W-1:0]);
          fails++;
        end
        if (m_tdata[ufcc_pkg::ELEM_W] !== want.bad) begin
          $display("%0t: bad_index mismatch, expected %0d, actual %0d",
                   $time, want.bad, m_tdata[ufcc_pkg::ELEM_W]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reload_sets(ufcc_pkg::COUNT_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gap_pct   = 25;
    stall_pct = 40;
    test_directed_extremes();
    test_count_clamp();
    test_rank_links();
    test_random_traffic();
    test_unthrottled_tail();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0t: %0d failures, %0d results outstanding",
               $time, fails, pending_replies.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ union_find_component_counter_core.f @@
sv/ufcc_pkg.sv
sv/ufcc_ram.sv
sv/union_find_component_counter_core.sv
tb/sv/union_find_component_counter_core_tb.sv
